// ===== rtl/core/ajet_pkg.sv =====
package ajet_pkg;

   localparam int unsigned CoordWidth = 10;
   localparam int unsigned CountWidth = 10;
   localparam int unsigned DataWidth  = 32;
   localparam int unsigned IndexWidth = 3;

   // Register indexes on the configuration port
   localparam logic [IndexWidth-1:0] REG_PIXEL_STEP = 3'd0;
   localparam logic [IndexWidth-1:0] REG_ORIGIN_RE  = 3'd1;
   localparam logic [IndexWidth-1:0] REG_ORIGIN_IM  = 3'd2;
   localparam logic [IndexWidth-1:0] REG_C_RE       = 3'd3;
   localparam logic [IndexWidth-1:0] REG_C_IM       = 3'd4;
   localparam logic [IndexWidth-1:0] REG_ITER_LIMIT = 3'd5;

   // Register reset values
   localparam logic [30:0] RST_PIXEL_STEP = 31'd191740;
   localparam logic [31:0] RST_ORIGIN_RE  = 32'hF800_0000;
   localparam logic [31:0] RST_ORIGIN_IM  = 32'hFA00_0000;
   localparam logic [31:0] RST_C_RE       = 32'd19126026;
   localparam logic [31:0] RST_C_IM       = 32'd671089;
   localparam logic [9:0]  RST_ITER_LIMIT = 10'd140;

   typedef struct packed {
      logic [30:0] pixel_step;
      logic [31:0] origin_re;
      logic [31:0] origin_im;
      logic [31:0] c_re;
      logic [31:0] c_im;
      logic [9:0]  iter_limit;
   } cfg_type;

   typedef struct packed {
      logic load;   // capture the coordinate
      logic init;   // form the start point, clear the count
      logic mul;    // register the three products
      logic step;   // take the next point, advance the count
   } cmd_type;

   typedef struct packed {
      logic finish;  // escaped or at the limit
   } sts_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INIT,
      ST_MUL,
      ST_TEST,
      ST_RESP
   } state_type;

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > 64'sd2147483647) begin
         r = 32'sh7FFF_FFFF;
      end else if (v < -64'sd2147483648) begin
         r = 32'sh8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   function automatic logic signed [31:0] abs_sat(input logic signed [31:0] v);
      logic signed [31:0] r;
      if (!v[31]) begin
         r = v;
      end else if (v == 32'sh8000_0000) begin
         r = 32'sh7FFF_FFFF;
      end else begin
         r = -v;
      end
      return r;
   endfunction

endpackage

// ===== rtl/core/ajet_ctrl.sv =====
module ajet_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  ajet_pkg::sts_type sts,
   output ajet_pkg::cmd_type cmd,
   output logic              busy,
   output logic              rsp_valid
);

   ajet_pkg::state_type state_ff;
   ajet_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ajet_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      busy      = 1'b1;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ajet_pkg::ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load = 1'b1;
               state_in = ajet_pkg::ST_INIT;
            end
         end
         ajet_pkg::ST_INIT: begin
            cmd.init = 1'b1;
            state_in = ajet_pkg::ST_MUL;
         end
         ajet_pkg::ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ajet_pkg::ST_TEST;
         end
         ajet_pkg::ST_TEST: begin
            if (sts.finish) begin
               state_in = ajet_pkg::ST_RESP;
            end else begin
               cmd.step = 1'b1;
               state_in = ajet_pkg::ST_MUL;
            end
         end
         ajet_pkg::ST_RESP: begin
            rsp_valid = 1'b1;
            state_in  = ajet_pkg::ST_IDLE;
         end
         default: begin
            state_in = ajet_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// ===== rtl/core/ajet_dpath.sv =====
module ajet_dpath #(
   parameter int IMAGE_X_SIZE = 1024,
   parameter int IMAGE_Y_SIZE = 1024,
   parameter int FRAC_BITS    = 26
) (
   input  logic              clock,
   input  ajet_pkg::cfg_type cfg,
   input  ajet_pkg::cmd_type cmd,
   input  logic [9:0]        req_pixel_col,
   input  logic [9:0]        req_pixel_row,
   output ajet_pkg::sts_type sts,
   output logic [9:0]        rsp_iter_count,
   output logic [9:0]        rsp_out_col,
   output logic [9:0]        rsp_out_row
);

   localparam logic [12:0] XSize = 13'(IMAGE_X_SIZE);
   localparam logic [12:0] YSize = 13'(IMAGE_Y_SIZE);
   localparam logic [9:0]  XLast = 10'(IMAGE_X_SIZE - 1);
   localparam logic [9:0]  YLast = 10'(IMAGE_Y_SIZE - 1);
   localparam logic [63:0] Bound = 64'd4 << (2 * FRAC_BITS);

   logic [9:0]         col_ff, row_ff;
   logic [9:0]         col_clamp, row_clamp;
   logic signed [31:0] re_ff, im_ff;
   logic signed [31:0] re_start, im_start, re_next, im_next;
   logic signed [42:0] col_prod, row_prod;
   logic signed [63:0] re_sum, im_sum;
   logic signed [63:0] rr_ff, ii_ff, ri_ff;
   logic signed [63:0] rr_in, ii_in, ri_in;
   logic signed [63:0] diff, re_acc, im_acc;
   logic [63:0]        mag;
   logic [9:0]         count_ff;

   // Coordinates past the image edge compute as the last column or row
   assign col_clamp = ({3'b000, col_ff} >= XSize) ? XLast : col_ff;
   assign row_clamp = ({3'b000, row_ff} >= YSize) ? YLast : row_ff;

   assign col_prod = $signed({1'b0, col_clamp}) * $signed({1'b0, cfg.pixel_step});
   assign row_prod = $signed({1'b0, row_clamp}) * $signed({1'b0, cfg.pixel_step});
   assign re_sum   = 64'(col_prod) + 64'($signed(cfg.origin_re));
   assign im_sum   = 64'(row_prod) + 64'($signed(cfg.origin_im));
   assign re_start = ajet_pkg::sat32(re_sum);
   assign im_start = ajet_pkg::sat32(im_sum);

   assign rr_in = re_ff * re_ff;
   assign ii_in = im_ff * im_ff;
   assign ri_in = re_ff * im_ff;

   // Squares are non-negative, so the unsigned sum cannot wrap
   assign mag        = $unsigned(rr_ff) + $unsigned(ii_ff);
   assign sts.finish = (mag >= Bound) || (count_ff >= cfg.iter_limit);

   assign diff    = rr_ff - ii_ff;
   assign re_acc  = (diff >>> FRAC_BITS) + 64'($signed(cfg.c_re));
   assign im_acc  = (ri_ff >>> (FRAC_BITS - 1)) + 64'($signed(cfg.c_im));
   assign re_next = ajet_pkg::abs_sat(ajet_pkg::sat32(re_acc));
   assign im_next = ajet_pkg::abs_sat(ajet_pkg::sat32(im_acc));

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         col_ff <= req_pixel_col;
         row_ff <= req_pixel_row;
      end
      if (cmd.init) begin
         re_ff    <= re_start;
         im_ff    <= im_start;
         count_ff <= '0;
      end else if (cmd.step) begin
         re_ff    <= re_next;
         im_ff    <= im_next;
         count_ff <= count_ff + 10'd1;
      end
      if (cmd.mul) begin
         rr_ff <= rr_in;
         ii_ff <= ii_in;
         ri_ff <= ri_in;
      end
   end

   assign rsp_iter_count = count_ff;
   assign rsp_out_col    = col_ff;
   assign rsp_out_row    = row_ff;

endmodule

// ===== rtl/core/abs_julia_escape_time.sv =====
// Burning-ship Julia escape-time unit. Pulse start while busy is low to
// transfer one pixel coordinate; the start point is coordinate * pixel_step +
// origin, and the map z' = (|re^2 - im^2 + c_re|, |2*re*im + c_im|) repeats
// until |z|^2 reaches 4 or the count reaches iter_limit. Each iteration first
// registers the three 32x32 products, then does the escape test and takes
// the next point. For a pixel with final count N, busy stays high after the
// start transfer while the unit forms the start point, runs the product and
// test steps for each of the N iterations and for the final escape test,
// and then pulses rsp_valid with the count and the echoed coordinate. The
// receiver cannot stall and must take the result in that cycle. Busy falls
// the cycle after the pulse; no new pixel is taken before then. Configuration
// writes belong in idle periods only.
module abs_julia_escape_time #(
   parameter int IMAGE_X_SIZE = 1024,
   parameter int IMAGE_Y_SIZE = 1024,
   parameter int FRAC_BITS    = 26
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [9:0]  req_pixel_col,
   input  logic [9:0]  req_pixel_row,
   output logic        rsp_valid,
   output logic [9:0]  rsp_iter_count,
   output logic [9:0]  rsp_out_col,
   output logic [9:0]  rsp_out_row,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   ajet_pkg::cfg_type cfg_ff;
   ajet_pkg::cmd_type cmd;
   ajet_pkg::sts_type sts;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pixel_step <= ajet_pkg::RST_PIXEL_STEP;
         cfg_ff.origin_re  <= ajet_pkg::RST_ORIGIN_RE;
         cfg_ff.origin_im  <= ajet_pkg::RST_ORIGIN_IM;
         cfg_ff.c_re       <= ajet_pkg::RST_C_RE;
         cfg_ff.c_im       <= ajet_pkg::RST_C_IM;
         cfg_ff.iter_limit <= ajet_pkg::RST_ITER_LIMIT;
      end else if (csr_we) begin
         unique case (csr_index)
            ajet_pkg::REG_PIXEL_STEP: cfg_ff.pixel_step <= csr_wdata[30:0];
            ajet_pkg::REG_ORIGIN_RE:  cfg_ff.origin_re  <= csr_wdata;
            ajet_pkg::REG_ORIGIN_IM:  cfg_ff.origin_im  <= csr_wdata;
            ajet_pkg::REG_C_RE:       cfg_ff.c_re       <= csr_wdata;
            ajet_pkg::REG_C_IM:       cfg_ff.c_im       <= csr_wdata;
            ajet_pkg::REG_ITER_LIMIT: cfg_ff.iter_limit <= csr_wdata[9:0];
            default: ;  // drop writes to unused indexes
         endcase
      end
   end

   ajet_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .sts       (sts),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   ajet_dpath #(
      .IMAGE_X_SIZE (IMAGE_X_SIZE),
      .IMAGE_Y_SIZE (IMAGE_Y_SIZE),
      .FRAC_BITS    (FRAC_BITS)
   ) u_dpath (
      .clock          (clock),
      .cfg            (cfg_ff),
      .cmd            (cmd),
      .req_pixel_col  (req_pixel_col),
      .req_pixel_row  (req_pixel_row),
      .sts            (sts),
      .rsp_iter_count (rsp_iter_count),
      .rsp_out_col    (rsp_out_col),
      .rsp_out_row    (rsp_out_row)
   );

endmodule
